// ----- sv/button_press_classifier_top_assert.svh -----
// Assertion macros for the button press classifier.
// Expects i_clk and i_rst_n in the scope of the including module.
`ifndef BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH

// Checked only while out of reset.
`define BPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define BPC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/bpc_pkg.sv -----
// Shared types and constants for the button press classifier.
// No dependencies.
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FIELD_W    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LEVEL = 3'd0,
        CFG_ARM_RELEASE  = 3'd1,
        CFG_DEBOUNCE     = 3'd2,
        CFG_MIN_PRESS    = 3'd3,
        CFG_LONG_PRESS   = 3'd4
    } t_cfg_idx;

    localparam logic                RST_ACTIVE_LEVEL = 1'b1;
    localparam logic [FIELD_W-1:0]  RST_ARM_RELEASE  = 16'd50;
    localparam logic [FIELD_W-1:0]  RST_DEBOUNCE     = 16'd3;
    localparam logic [FIELD_W-1:0]  RST_MIN_PRESS    = 16'd5;
    localparam logic [FIELD_W-1:0]  RST_LONG_PRESS   = 16'd300;
    localparam logic [FIELD_W-1:0]  HELD_MAX         = 16'hFFFF;

endpackage

// ----- sv/button_press_classifier_top.sv -----
// Button press classifier top level: one raw sample in, one classified result out per transfer.
// Depends on bpc_pkg and button_press_classifier_top_assert.svh.
// The result of a sample is registered and can be taken in the cycle after its input transfer.
// Throughput: one sample per cycle if results are taken; one combinational pass feeds the state
// and the result register, and the input stays open while the waiting result is being taken.
// Reset (synchronous, active low) clears the state, drops any pending result, restores defaults.
`timescale 1ns / 1ps

module button_press_classifier_top
    import bpc_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // sample channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_raw_level,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_is_armed,
    output logic                  o_button_down,
    output logic                  o_press_event,
    output logic                  o_long_press_event,
    output logic                  o_short_press_event,
    output logic                  o_power_off_request,
    output logic [FIELD_W-1:0]    o_held_ticks
);

    // Compare width: ages and 16-bit thresholds meet at the wider of the two.
    localparam int CW = (TIMER_BITS > FIELD_W) ? TIMER_BITS : FIELD_W;

    // Configuration registers
    logic                  r_active_level;
    logic [FIELD_W-1:0]    r_arm_ticks;
    logic [FIELD_W-1:0]    r_deb_ticks;
    logic [FIELD_W-1:0]    r_min_ticks;
    logic [FIELD_W-1:0]    r_long_ticks;

    // Classifier state
    logic                  r_armed;
    logic                  r_last_raw;
    logic                  r_stable_down;
    logic                  r_long_seen;
    logic [TIMER_BITS-1:0] r_release_age;
    logic [TIMER_BITS-1:0] r_change_age;
    logic [TIMER_BITS-1:0] r_hold_age;

    // Next state; the *_b ages are the values after this tick's restarts,
    // before the end-of-tick increment.
    logic                  n_armed;
    logic                  n_last_raw;
    logic                  n_stable_down;
    logic                  n_long_seen;
    logic [TIMER_BITS-1:0] rel_b;
    logic [TIMER_BITS-1:0] chg_b;
    logic [TIMER_BITS-1:0] hold_b;
    logic [TIMER_BITS-1:0] n_release_age;
    logic [TIMER_BITS-1:0] n_change_age;
    logic [TIMER_BITS-1:0] n_hold_age;

    logic                  w_pressed;
    logic                  w_released_now;
    logic                  w_press_ev;
    logic                  w_long_ev;
    logic                  w_short_ev;
    logic                  w_off_ev;
    logic [CW-1:0]         w_held;
    logic [FIELD_W-1:0]    w_held_sat;

    // Output register
    logic                  r_out_valid;
    logic                  r_is_armed;
    logic                  r_button_down;
    logic                  r_press_event;
    logic                  r_long_press_event;
    logic                  r_short_press_event;
    logic                  r_power_off_request;
    logic [FIELD_W-1:0]    r_held_ticks;

    logic                  in_xfer;

    // Result summaries watched by the checks at the end
    logic                  w_rel_both;
    logic                  w_out_busy;

    // Take a sample whenever the output slot is empty or drains this cycle.
    assign o_ready = !r_out_valid || i_ready;
    assign in_xfer = i_valid && o_ready;

    assign w_pressed = (i_raw_level == r_active_level);

    always_comb begin
        n_armed        = r_armed;
        n_last_raw     = r_last_raw;
        n_stable_down  = r_stable_down;
        n_long_seen    = r_long_seen;
        rel_b          = r_release_age;
        chg_b          = r_change_age;
        hold_b         = r_hold_age;
        w_released_now = 1'b0;
        w_press_ev     = 1'b0;
        w_long_ev      = 1'b0;
        w_short_ev     = 1'b0;
        w_off_ev       = 1'b0;
        w_held         = '0;

        if (!r_armed) begin
            // Unarmed: wait for a long enough release, no debouncing.
            if (w_pressed) begin
                rel_b = '0;
            end else if (CW'(r_release_age) >= CW'(r_arm_ticks)) begin
                n_armed       = 1'b1;
                n_last_raw    = 1'b0;
                n_stable_down = 1'b0;
                chg_b         = '0;
            end
        end else begin
            // Any raw change restarts the stability timer.
            if (w_pressed != r_last_raw) begin
                n_last_raw = w_pressed;
                chg_b      = '0;
            end
            // Accept the level once it has been stable long enough.
            if ((w_pressed != r_stable_down) && (CW'(chg_b) >= CW'(r_deb_ticks))) begin
                n_stable_down = w_pressed;
                if (w_pressed) begin
                    hold_b      = '0;
                    n_long_seen = 1'b0;
                    w_press_ev  = 1'b1;
                end else begin
                    // Release: classify the press that just ended.
                    w_released_now = 1'b1;
                    w_held         = CW'(r_hold_age);
                    if (r_long_seen || (CW'(r_hold_age) >= CW'(r_long_ticks))) begin
                        w_off_ev = 1'b1;
                    end else if (CW'(r_hold_age) >= CW'(r_min_ticks)) begin
                        w_short_ev = 1'b1;
                    end
                end
            end
            // Flag a long press while still held, once per press.
            if (n_stable_down && !n_long_seen && (CW'(hold_b) >= CW'(r_long_ticks))) begin
                n_long_seen = 1'b1;
                w_long_ev   = 1'b1;
            end
            if (n_stable_down) begin
                w_held = CW'(hold_b);
            end else if (!w_released_now) begin
                w_held = '0;
            end
        end
    end

    // Every age grows by one at the end of the tick, saturating at all ones.
    assign n_release_age = (&rel_b)  ? rel_b  : rel_b  + TIMER_BITS'(1);
    assign n_change_age  = (&chg_b)  ? chg_b  : chg_b  + TIMER_BITS'(1);
    assign n_hold_age    = (&hold_b) ? hold_b : hold_b + TIMER_BITS'(1);

    // Clamp the held time to the 16-bit result field.
    assign w_held_sat = (w_held > CW'(HELD_MAX)) ? HELD_MAX : w_held[FIELD_W-1:0];

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_level <= RST_ACTIVE_LEVEL;
            r_arm_ticks    <= RST_ARM_RELEASE;
            r_deb_ticks    <= RST_DEBOUNCE;
            r_min_ticks    <= RST_MIN_PRESS;
            r_long_ticks   <= RST_LONG_PRESS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACTIVE_LEVEL: r_active_level <= i_cfg_data[0];
                CFG_ARM_RELEASE:  r_arm_ticks    <= i_cfg_data;
                CFG_DEBOUNCE:     r_deb_ticks    <= i_cfg_data;
                CFG_MIN_PRESS:    r_min_ticks    <= i_cfg_data;
                CFG_LONG_PRESS:   r_long_ticks   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the classifier state on each sample transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed       <= 1'b0;
            r_last_raw    <= 1'b0;
            r_stable_down <= 1'b0;
            r_long_seen   <= 1'b0;
            r_release_age <= '0;
            r_change_age  <= '0;
            r_hold_age    <= '0;
        end else if (in_xfer) begin
            r_armed       <= n_armed;
            r_last_raw    <= n_last_raw;
            r_stable_down <= n_stable_down;
            r_long_seen   <= n_long_seen;
            r_release_age <= n_release_age;
            r_change_age  <= n_change_age;
            r_hold_age    <= n_hold_age;
        end
    end

    // Result slot: fill on a sample transfer, empty when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; hold while stalled.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_is_armed          <= n_armed;
            r_button_down       <= n_stable_down;
            r_press_event       <= w_press_ev;
            r_long_press_event  <= w_long_ev;
            r_short_press_event <= w_short_ev;
            r_power_off_request <= w_off_ev;
            r_held_ticks        <= w_held_sat;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_is_armed          = r_is_armed;
    assign o_button_down       = r_button_down;
    assign o_press_event       = r_press_event;
    assign o_long_press_event  = r_long_press_event;
    assign o_short_press_event = r_short_press_event;
    assign o_power_off_request = r_power_off_request;
    assign o_held_ticks        = r_held_ticks;

    assign w_rel_both = o_short_press_event && o_power_off_request;
    assign w_out_busy = o_button_down || o_press_event || o_long_press_event
                        || o_short_press_event || o_power_off_request || (|o_held_ticks);

`include "button_press_classifier_top_assert.svh"

    // A release is either short or long, never both.
    `BPC_ASSERT(a_release_exclusive, o_valid |-> !w_rel_both, "short and long release together")
    // Unarmed results carry no events, no press and no held time.
    `BPC_ASSERT(a_unarmed_quiet, (o_valid && !o_is_armed) |-> !w_out_busy, "activity while unarmed")
    // A press begins down with zero held time.
    `BPC_ASSERT(a_press_start, (o_valid && o_press_event) |-> (o_button_down && (o_held_ticks == '0)), "bad press start")
    // Once armed, the block stays armed.
    `BPC_ASSERT(a_armed_sticky, r_armed |=> r_armed, "armed flag dropped")
    // Reset empties the result slot.
    `BPC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule
